>>> sv/sbt_pkg.sv
package sbt_pkg;

    // Default geometry
    localparam int GRID_SIDE_DEF  = 64;
    localparam int POOL_ROWS_DEF  = 64;
    localparam int SLOTS_DEF      = 16;
    localparam int CELL_SHIFT_DEF = 10;

    // Field widths of the words on the ports
    localparam int POS_W   = 16;
    localparam int VAL_W   = 32;
    localparam int LINK_W  = 13;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int REQ_W   = 2;

    // Widest bucket number over the whole parameter range (256*256 + 256*256)
    localparam int BKT_MAX_W = 17;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RD_POS  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RD_LINK = 2'd3;

    // Status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_DROPPED = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [VAL_W-1:0]  value;
        logic [LINK_W-1:0] link;
    } t_in_word;

    typedef struct packed {
        logic              status;
        logic [VAL_W-1:0]  entry_value;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  entry_count;
        logic [LINK_W-1:0] next_link;
        logic              is_last;
    } t_out_word;

    // Classified request handed from front to back
    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [BKT_MAX_W-1:0] bucket;
        logic [VAL_W-1:0]     value;
        logic                 out_of_range;
    } t_cmd;

endpackage

>>> sv/sbt_ram.sv
module sbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/sbt_queue.sv
module sbt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sbt_pkg::t_cmd o_cmd
);
    import sbt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 2'd1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

>>> sv/sbt_front.sv
module sbt_front #(
    parameter int GRID_SIDE  = sbt_pkg::GRID_SIDE_DEF,
    parameter int POOL_ROWS  = sbt_pkg::POOL_ROWS_DEF,
    parameter int CELL_SHIFT = sbt_pkg::CELL_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sbt_pkg::t_in_word i_in_word,
    output logic              o_in_stall,
    output logic              o_push,
    output sbt_pkg::t_cmd     o_cmd,
    input  logic              i_q_full
);
    import sbt_pkg::*;

    localparam int TOTAL  = GRID_SIDE * GRID_SIDE + POOL_ROWS * GRID_SIDE;
    localparam int RW     = $clog2(GRID_SIDE) + 1;
    localparam int RCP_W  = 32;
    localparam int PRD_W  = POS_W + RCP_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_QUO  = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    // Scaled reciprocal of the grid side; exact quotient for any 16-bit coordinate
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'((64'd1 << RCP_W) / 64'(GRID_SIDE) + 64'd1);
    localparam logic [POS_W-1:0] GRID_P = POS_W'(GRID_SIDE);

    logic [1:0]        r_state, n_state;
    logic [POS_W-1:0]  r_xv, n_xv, r_yv, n_yv;
    logic [POS_W-1:0]  r_xq, n_xq, r_yq, n_yq;
    logic [RW-1:0]     r_xr, n_xr, r_yr, n_yr;
    t_cmd              r_cmd, n_cmd;
    logic [PRD_W-1:0]  w_xprod, w_yprod;
    logic [POS_W-1:0]  w_xrem, w_yrem;
    logic              w_accept;

    assign o_in_stall = (r_state != F_IDLE);
    assign w_accept   = i_in_valid && (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH);

    // Quotient by reciprocal multiply, then remainder by one multiply-subtract
    assign w_xprod = PRD_W'(r_xv) * PRD_W'(RECIP);
    assign w_yprod = PRD_W'(r_yv) * PRD_W'(RECIP);
    assign w_xrem  = r_xv - r_xq * GRID_P;
    assign w_yrem  = r_yv - r_yq * GRID_P;

    always_comb begin
        n_state = r_state;
        n_xv    = r_xv;
        n_yv    = r_yv;
        n_xq    = r_xq;
        n_yq    = r_yq;
        n_xr    = r_xr;
        n_yr    = r_yr;
        n_cmd   = r_cmd;
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_cmd.req_type     = i_in_word.req_type;
                    n_cmd.value        = i_in_word.value;
                    n_cmd.bucket       = BKT_MAX_W'(i_in_word.link);
                    n_cmd.out_of_range = 1'b0;
                    n_xv   = i_in_word.pos_x >> CELL_SHIFT;
                    n_yv   = i_in_word.pos_y >> CELL_SHIFT;
                    if (i_in_word.req_type == REQ_RD_LINK) begin
                        n_cmd.out_of_range = (32'(i_in_word.link) >= 32'(TOTAL));
                        n_state = F_PUSH;
                    end else if (i_in_word.req_type == REQ_CLEAR) begin
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_QUO;
                    end
                end
            end
            F_QUO: begin
                n_xq    = w_xprod[PRD_W-1:RCP_W];
                n_yq    = w_yprod[PRD_W-1:RCP_W];
                n_state = F_REM;
            end
            F_REM: begin
                n_xr    = w_xrem[RW-1:0];
                n_yr    = w_yrem[RW-1:0];
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Bucket number from the grid cell for position requests
    always_comb begin
        o_cmd = r_cmd;
        if (r_cmd.req_type == REQ_ADD || r_cmd.req_type == REQ_RD_POS) begin
            o_cmd.bucket = BKT_MAX_W'(r_yr) * BKT_MAX_W'(GRID_SIDE) + BKT_MAX_W'(r_xr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_xv   <= n_xv;
        r_yv   <= n_yv;
        r_xq   <= n_xq;
        r_yq   <= n_yq;
        r_xr   <= n_xr;
        r_yr   <= n_yr;
        r_cmd  <= n_cmd;
    end

endmodule

>>> sv/sbt_back.sv
module sbt_back #(
    parameter int GRID_SIDE        = sbt_pkg::GRID_SIDE_DEF,
    parameter int POOL_ROWS        = sbt_pkg::POOL_ROWS_DEF,
    parameter int SLOTS_PER_BUCKET = sbt_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sbt_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    output sbt_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import sbt_pkg::*;

    localparam int PRIMARY   = GRID_SIDE * GRID_SIDE;
    localparam int POOL_BKTS = POOL_ROWS * GRID_SIDE;
    localparam int TOTAL     = PRIMARY + POOL_BKTS;
    localparam int BW        = $clog2(TOTAL);
    localparam int CW        = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int PW        = $clog2(POOL_BKTS + 1);
    localparam int MW        = CW + BW;
    localparam int VDEPTH    = TOTAL * SLOTS_PER_BUCKET;
    localparam int VAW       = $clog2(VDEPTH);

    localparam logic [2:0] S_INIT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_CLR     = 3'd2;
    localparam logic [2:0] S_ADD_RD  = 3'd3;
    localparam logic [2:0] S_ADD_CHK = 3'd4;
    localparam logic [2:0] S_RD_RD   = 3'd5;
    localparam logic [2:0] S_RD_META = 3'd6;
    localparam logic [2:0] S_RD_SLOT = 3'd7;

    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS_PER_BUCKET);

    logic [2:0]       r_state, n_state;
    logic [BW-1:0]    r_sweep, n_sweep;
    logic [PW-1:0]    r_pool, n_pool;
    logic [BW-1:0]    r_cur, n_cur;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_oor, n_oor;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [BW-1:0]    r_link, n_link;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic             w_out_free;
    logic             m_we, m_re, v_we, v_re;
    logic [BW-1:0]    m_waddr, m_raddr;
    logic [MW-1:0]    m_wdata, m_rdata;
    logic [CW-1:0]    m_cnt;
    logic [BW-1:0]    m_link;
    logic [VAW-1:0]   w_base, v_waddr, v_raddr;
    logic [VAL_W-1:0] v_rdata;
    logic [BW-1:0]    w_new_bkt;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign {m_cnt, m_link} = m_rdata;
    assign w_base    = VAW'(r_cur) * VAW'(SLOTS_PER_BUCKET);
    assign w_new_bkt = BW'(PRIMARY) + BW'(r_pool);
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Count and link per bucket
    sbt_ram #(.WIDTH(MW), .DEPTH(TOTAL)) u_meta (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_re   (m_re),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    // Slot values, never cleared
    sbt_ram #(.WIDTH(VAL_W), .DEPTH(VDEPTH)) u_vals (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(v_waddr),
        .i_wdata(r_val),
        .i_re   (v_re),
        .i_raddr(v_raddr),
        .o_rdata(v_rdata)
    );

    // Request sequencer
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_pool      = r_pool;
        n_cur       = r_cur;
        n_val       = r_val;
        n_oor       = r_oor;
        n_cnt       = r_cnt;
        n_link      = r_link;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        m_we    = 1'b0;
        m_waddr = r_cur;
        m_wdata = '0;
        m_re    = 1'b0;
        m_raddr = r_cur;
        v_we    = 1'b0;
        v_waddr = w_base + VAW'(m_cnt);
        v_re    = 1'b0;
        v_raddr = w_base;
        case (r_state)
            S_INIT, S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_sweep;
                if (r_sweep == BW'(TOTAL - 1)) begin
                    n_pool = '0;
                    if (r_state == S_INIT) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.is_last = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_sweep = r_sweep + BW'(1);
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cur   = BW'(i_cmd.bucket);
                    n_val   = i_cmd.value;
                    n_oor   = i_cmd.out_of_range;
                    n_sweep = '0;
                    case (i_cmd.req_type)
                        REQ_CLEAR: n_state = S_CLR;
                        REQ_ADD:   n_state = S_ADD_RD;
                        default:   n_state = S_RD_RD;
                    endcase
                end
            end
            S_ADD_RD: begin
                m_re    = 1'b1;
                n_state = S_ADD_CHK;
            end
            S_ADD_CHK: begin
                if (m_cnt < SLOTS_C) begin
                    if (w_out_free) begin
                        v_we    = 1'b1;
                        m_we    = 1'b1;
                        m_wdata = {m_cnt + CW'(1), m_link};
                        n_out_valid = 1'b1;
                        n_out.status      = ST_DONE;
                        n_out.entry_value = '0;
                        n_out.slot_index  = SLOT_W'(m_cnt);
                        n_out.entry_count = CNT_W'(m_cnt + CW'(1));
                        n_out.next_link   = LINK_W'(m_link);
                        n_out.is_last     = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (m_link != '0) begin
                    n_cur   = m_link;
                    n_state = S_ADD_RD;
                end else if (r_pool >= PW'(POOL_BKTS)) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out.status      = ST_DROPPED;
                        n_out.entry_value = '0;
                        n_out.slot_index  = '0;
                        n_out.entry_count = CNT_W'(m_cnt);
                        n_out.next_link   = LINK_W'(m_link);
                        n_out.is_last     = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    // chain a fresh pool bucket; its count and link are zero
                    m_we    = 1'b1;
                    m_wdata = {m_cnt, w_new_bkt};
                    n_pool  = r_pool + PW'(1);
                    n_cur   = w_new_bkt;
                    n_state = S_ADD_RD;
                end
            end
            S_RD_RD: begin
                if (r_oor) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.is_last = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    m_re    = 1'b1;
                    n_state = S_RD_META;
                end
            end
            S_RD_META: begin
                n_cnt  = m_cnt;
                n_link = m_link;
                if (m_cnt == '0) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.next_link = LINK_W'(m_link);
                        n_out.is_last   = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx   = '0;
                    v_re    = 1'b1;
                    n_state = S_RD_SLOT;
                end
            end
            S_RD_SLOT: begin
                v_raddr = w_base + VAW'(r_idx + CW'(1));
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.status      = ST_DONE;
                    n_out.entry_value = v_rdata;
                    n_out.slot_index  = SLOT_W'(r_idx);
                    n_out.entry_count = CNT_W'(r_cnt);
                    n_out.next_link   = LINK_W'(r_link);
                    n_out.is_last     = (r_idx + CW'(1) == r_cnt);
                    if (r_idx + CW'(1) == r_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        v_re  = 1'b1;
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_pool      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_pool      <= n_pool;
            r_out_valid <= n_out_valid;
        end
        r_cur  <= n_cur;
        r_val  <= n_val;
        r_oor  <= n_oor;
        r_cnt  <= n_cnt;
        r_link <= n_link;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    // Pool allocation never runs past the pool
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool <= PW'(POOL_BKTS))
        else $error("pool index beyond pool");

    // Slot walk stays inside the filled slots
    a_slot_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_SLOT) |-> (r_idx < r_cnt && r_cnt <= SLOTS_C))
        else $error("slot index beyond fill count");

    // A queue word is only taken when the sequencer is free
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_CLR || r_state == S_ADD_RD || r_state == S_RD_RD))
        else $error("request popped without starting");

endmodule

>>> sv/spatial_bucket_table_with_overflow_core.sv
// Spatial bucket table: a GRID_SIDE x GRID_SIDE grid of buckets picked by
// (pos >> CELL_SHIFT) mod GRID_SIDE, plus POOL_ROWS*GRID_SIDE overflow
// buckets chained on in order when a chain's last bucket fills. After reset
// the count/link memory is swept to zero, one bucket a cycle (TOTAL buckets,
// 8192 at defaults), before the first request starts. Per request, with the
// count/link memory (one read and one write port) and the slot memory:
// position requests pass the front's reciprocal quotient and remainder
// steps before the push; a read fetches count and link, then the filled
// slots in turn (an out-of-range link read skips the memories); an add
// reads and checks each bucket walked, plus a write and a new read for a
// pool link; a clear rewrites every bucket's count and link. A two-word
// queue lets the front classify the next request while the back is busy, and
// the result register lets new work proceed while a result waits to be taken.
module spatial_bucket_table_with_overflow_core #(
    parameter int GRID_SIDE        = sbt_pkg::GRID_SIDE_DEF,
    parameter int POOL_ROWS        = sbt_pkg::POOL_ROWS_DEF,
    parameter int SLOTS_PER_BUCKET = sbt_pkg::SLOTS_DEF,
    parameter int CELL_SHIFT       = sbt_pkg::CELL_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sbt_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output sbt_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import sbt_pkg::*;

    logic w_push, w_full, w_pop, w_q_valid;
    t_cmd w_push_cmd, w_q_cmd;

    // Front: take words, find the bucket
    sbt_front #(
        .GRID_SIDE (GRID_SIDE),
        .POOL_ROWS (POOL_ROWS),
        .CELL_SHIFT(CELL_SHIFT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_word (i_in_word),
        .o_in_stall(o_in_stall),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_q_full  (w_full)
    );

    // Short queue between the halves
    sbt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_cmd  (w_q_cmd)
    );

    // Back: memories and result words
    sbt_back #(
        .GRID_SIDE       (GRID_SIDE),
        .POOL_ROWS       (POOL_ROWS),
        .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_cmd      (w_q_cmd),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

endmodule

>>> tb/tb.sv
module tb;
    import sbt_pkg::*;

    localparam int GRID      = 64;
    localparam int SLOTS     = 16;
    localparam int SHIFT     = 10;
    localparam int PRIMARY   = GRID * GRID;
    localparam int POOL      = 64 * GRID;
    localparam int TOTAL     = PRIMARY + POOL;

    // Bucket table model: predicts the words each request produces
    class bucket_table_sb;
        logic [VAL_W-1:0]  vals [int];
        logic [CNT_W-1:0]  counts [TOTAL];
        logic [LINK_W-1:0] links [TOTAL];
        int                next_free;
        t_out_word         pending [$];
        int                errors;

        function void wipe();
            foreach (counts[i]) begin
                counts[i] = '0;
                links[i] = '0;
            end
            next_free = 0;
        endfunction

        function int bucket_of(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
            return ((py >> SHIFT) % GRID) * GRID + ((px >> SHIFT) % GRID);
        endfunction

        function void push(logic st, logic [VAL_W-1:0] v, int slot, int cnt, int nxt,
                           logic last);
            t_out_word w;
            w.status = st;
            w.entry_value = v;
            w.slot_index = slot[SLOT_W-1:0];
            w.entry_count = cnt[CNT_W-1:0];
            w.next_link = nxt[LINK_W-1:0];
            w.is_last = last;
            pending.push_back(w);
        endfunction

        function void emit_bucket(int b);
            int cnt;
            if (b >= TOTAL) begin
                push(ST_DONE, '0, 0, 0, 0, 1'b1);
                return;
            end
            cnt = int'(counts[b]);
            if (cnt == 0) begin
                push(ST_DONE, '0, 0, 0, int'(links[b]), 1'b1);
                return;
            end
            for (int i = 0; i < cnt; i++)
                push(ST_DONE, vals[b * SLOTS + i], i, cnt, int'(links[b]), i + 1 == cnt);
        endfunction

        function void insert(int b, logic [VAL_W-1:0] v);
            int nxt;
            int slot;
            while (counts[b] >= SLOTS) begin
                nxt = int'(links[b]);
                if (nxt == 0) begin
                    if (next_free >= POOL) begin
                        push(ST_DROPPED, '0, 0, int'(counts[b]), int'(links[b]), 1'b1);
                        return;
                    end
                    nxt = PRIMARY + next_free;
                    next_free++;
                    counts[nxt] = '0;
                    links[nxt] = '0;
                    links[b] = nxt[LINK_W-1:0];
                end
                b = nxt;
            end
            slot = int'(counts[b]);
            vals[b * SLOTS + slot] = v;
            counts[b] = CNT_W'(slot + 1);
            push(ST_DONE, '0, slot, slot + 1, int'(links[b]), 1'b1);
        endfunction

        // Note one accepted request word
        function void note_request(t_in_word w);
            case (w.req_type)
                REQ_CLEAR: begin
                    wipe();
                    push(ST_DONE, '0, 0, 0, 0, 1'b1);
                end
                REQ_ADD:    insert(bucket_of(w.pos_x, w.pos_y), w.value);
                REQ_RD_POS: emit_bucket(bucket_of(w.pos_x, w.pos_y));
                default:    emit_bucket(int'(w.link));
            endcase
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(t_out_word got);
            t_out_word exp;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status exp %0d got %0d", exp.status, got.status);
                errors++;
            end
            if (got.entry_value !== exp.entry_value) begin
                $error("entry_value exp %h got %h", exp.entry_value, got.entry_value);
                errors++;
            end
            if (got.slot_index !== exp.slot_index) begin
                $error("slot_index exp %0d got %0d", exp.slot_index, got.slot_index);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count exp %0d got %0d", exp.entry_count, got.entry_count);
                errors++;
            end
            if (got.next_link !== exp.next_link) begin
                $error("next_link exp %0d got %0d", exp.next_link, got.next_link);
                errors++;
            end
            if (got.is_last !== exp.is_last) begin
                $error("is_last exp %0d got %0d", exp.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_word  i_in_word;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall;

    bucket_table_sb table_sb;
    bit        hold_long;
    bit        stim_done;
    // Positions already filled, so reads by position hit known buckets
    logic [POS_W-1:0] used_x [$];
    logic [POS_W-1:0] used_y [$];

    spatial_bucket_table_with_overflow_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until it is taken; valid drops only for a gap
    task automatic send_word(t_in_word w);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        table_sb.note_request(w);
    endtask

    task automatic send_req(logic [REQ_W-1:0] rq, logic [POS_W-1:0] px,
                            logic [POS_W-1:0] py, logic [VAL_W-1:0] v,
                            logic [LINK_W-1:0] lk);
        t_in_word w;
        w.req_type = rq;
        w.pos_x = px;
        w.pos_y = py;
        w.value = v;
        w.link = lk;
        send_word(w);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (table_sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Random request, mostly adds and reads on a few busy cells
    task automatic random_req();
        int r;
        int k;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        r = $urandom_range(0, 99);
        px = POS_W'($urandom);
        py = POS_W'($urandom);
        if (used_x.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, used_x.size() - 1);
            px = used_x[k] ^ POS_W'($urandom & 16'h03ff);
            py = used_y[k] ^ POS_W'($urandom & 16'h03ff);
        end
        if (r < 50) begin
            used_x.push_back(px);
            used_y.push_back(py);
            send_req(REQ_ADD, px, py, $urandom, LINK_W'($urandom));
        end else if (r < 75) begin
            send_req(REQ_RD_POS, px, py, $urandom, LINK_W'($urandom));
        end else if (r < 97) begin
            if ($urandom_range(0, 3) == 0)
                send_req(REQ_RD_LINK, px, py, $urandom, LINK_W'($urandom));
            else
                send_req(REQ_RD_LINK, px, py, $urandom,
                         LINK_W'(PRIMARY + $urandom_range(0, 7)));
        end else begin
            send_req(REQ_CLEAR, px, py, $urandom, LINK_W'($urandom));
            used_x.delete();
            used_y.delete();
        end
    endtask

    // Stimulus
    initial begin
        table_sb = new();
        table_sb.wipe();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        hold_long = 1'b0;
        stim_done = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty reads, extremes, one chain overflow, clear
        send_req(REQ_RD_POS, 16'h0000, 16'h0000, '0, '0);
        send_req(REQ_RD_LINK, '0, '0, '0, 13'h1fff);
        send_req(REQ_RD_LINK, '0, '0, '0, LINK_W'(TOTAL - 1));
        send_req(REQ_ADD, 16'hffff, 16'hffff, 32'hffffffff, 13'h1fff);
        send_req(REQ_ADD, 16'hffff, 16'hffff, 32'h00000000, '0);
        send_req(REQ_RD_POS, 16'hfc00, 16'hfc00, '0, '0);
        for (int i = 0; i < 17; i++)
            send_req(REQ_ADD, 16'h0400, 16'h0000, 32'ha5a50000 + i, '0);
        send_req(REQ_RD_POS, 16'h07ff, 16'h03ff, '0, '0);
        send_req(REQ_RD_LINK, '0, '0, '0, LINK_W'(PRIMARY));
        send_req(REQ_CLEAR, '0, '0, '0, '0);
        send_req(REQ_RD_POS, 16'h0400, 16'h0000, '0, '0);
        wait_drained();

        // Receiver holds off long while requests keep coming
        hold_long = 1'b1;
        for (int i = 0; i < 20; i++)
            random_req();
        wait_drained();
        for (int i = 0; i < 140; i++) begin
            random_req();
            if (i == 70)
                wait_drained();
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stall, one long hold-off
    initial begin
        int gap;
        i_out_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end
            gap = gap_len();
            if ($urandom_range(0, 1) == 0)
                gap = 0;
            i_out_stall <= gap != 0;
            repeat (gap == 0 ? $urandom_range(1, 20) : gap) @(posedge i_clk);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            table_sb.check_result(o_out_word);
    end

    // End of run
    initial begin
        int waited;
        waited = 0;
        @(posedge stim_done);
        while (table_sb.pending.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10000) @(posedge i_clk);
        if (table_sb.errors == 0 && table_sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/sbt_pkg.sv
sv/sbt_ram.sv
sv/sbt_queue.sv
sv/sbt_front.sv
sv/sbt_back.sv
sv/spatial_bucket_table_with_overflow_core.sv
tb/tb.sv
